[hw/rtl/key_debounce_long_press_macros.svh]
// ----------------------------------------------------------------------------
// key_debounce_long_press assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH

// same-cycle implication
`define KDLP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("key_debounce_long_press: same-cycle check failed");

// next-cycle implication
`define KDLP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key_debounce_long_press: next-cycle check failed");

`endif

[hw/rtl/kdlp_pkg.sv]
// ----------------------------------------------------------------------------
// kdlp_pkg
// Types and constants shared by the key debounce / long-press block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kdlp_pkg;

	localparam int NUM_KEYS_DEF    = 4;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int FIELD_KEYS = 4;
	localparam int CFG_W      = 16;
	localparam int REG_IDX_W  = 1;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd1200;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd10000;

	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_QUAL    = 2'd1,
		PH_PRESSED = 2'd2,
		PH_LONG    = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   pending;
		logic   press_hit;
		logic   long_hit;
	} lane_res_t;

endpackage

`default_nettype wire

[hw/rtl/kdlp_lane.sv]
// ----------------------------------------------------------------------------
// kdlp_lane
// Per-key phase tracker: phase, saturating tick counter and pending flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdlp_lane import kdlp_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             down,
	input  wire logic             ack,
	input  wire logic [CFG_W-1:0] debounce,
	input  wire logic [CFG_W-1:0] long_press,
	output lane_res_t             res
);

	localparam int CW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

	phase_t                 phase_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   pend_q;

	phase_t                 phase_d;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [CW-1:0]          cnt_ext;
	logic                   pend_d;
	logic                   press_hit;
	logic                   long_hit;
	logic                   clear_new;

	always_comb begin
		cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
		cnt_ext   = CW'(cnt_inc);
		phase_d   = phase_q;
		press_hit = 1'b0;
		long_hit  = 1'b0;
		clear_new = 1'b0;
		if (!down) begin
			phase_d = PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					phase_d   = PH_QUAL;
					clear_new = 1'b1;
				end
				PH_QUAL: begin
					if (cnt_ext >= CW'(debounce)) begin
						phase_d   = PH_PRESSED;
						press_hit = 1'b1;
					end
				end
				PH_PRESSED: begin
					if (cnt_ext >= CW'(long_press)) begin
						phase_d  = PH_LONG;
						long_hit = 1'b1;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
		pend_d = pend_q & ~ack & ~clear_new;
		if (press_hit || long_hit) begin
			pend_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= (phase_d != phase_q) ? '0 : cnt_inc;
			pend_q  <= pend_d;
		end
	end

	assign res.phase     = phase_d;
	assign res.pending   = pend_d;
	assign res.press_hit = press_hit;
	assign res.long_hit  = long_hit;

endmodule

`default_nettype wire

[hw/rtl/kdlp_merge.sv]
// ----------------------------------------------------------------------------
// kdlp_merge
// Packs the lane results into the output fields and holds the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kdlp_merge import kdlp_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        load,
	input  wire logic                        out_ready,
	input  wire lane_res_t [NUM_KEYS-1:0]    lanes,
	output logic                             out_valid,
	output logic [2*FIELD_KEYS-1:0]          key_states,
	output logic [FIELD_KEYS-1:0]            pending_mask,
	output logic [FIELD_KEYS-1:0]            press_events,
	output logic [FIELD_KEYS-1:0]            long_events
);

	logic [2*FIELD_KEYS-1:0] states_d;
	logic [FIELD_KEYS-1:0]   pend_d;
	logic [FIELD_KEYS-1:0]   press_d;
	logic [FIELD_KEYS-1:0]   long_d;

	logic                    valid_q;
	logic [2*FIELD_KEYS-1:0] states_q;
	logic [FIELD_KEYS-1:0]   pend_q;
	logic [FIELD_KEYS-1:0]   press_q;
	logic [FIELD_KEYS-1:0]   long_q;

	for (genvar i = 0; i < FIELD_KEYS; i++) begin : g_pack
		if (i < NUM_KEYS) begin : g_key
			assign states_d[2*i +: 2] = lanes[i].phase;
			assign pend_d[i]          = lanes[i].pending;
			assign press_d[i]         = lanes[i].press_hit;
			assign long_d[i]          = lanes[i].long_hit;
		end else begin : g_none
			assign states_d[2*i +: 2] = 2'b00;
			assign pend_d[i]          = 1'b0;
			assign press_d[i]         = 1'b0;
			assign long_d[i]          = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			states_q <= states_d;
			pend_q   <= pend_d;
			press_q  <= press_d;
			long_q   <= long_d;
		end
	end

	assign out_valid    = valid_q;
	assign key_states   = states_q;
	assign pending_mask = pend_q;
	assign press_events = press_q;
	assign long_events  = long_q;

endmodule

`default_nettype wire

[hw/rtl/key_debounce_long_press.sv]
// ----------------------------------------------------------------------------
// key_debounce_long_press
// Debounce and long-press detection for a bank of active-low keys.
// ----------------------------------------------------------------------------
// Each item is one tick: key levels plus an acknowledge mask. One key lane per
// key advances its phase, tick counter and pending flag in the cycle the item
// is taken, and the merged result is in an output register from the next cycle.
// The block takes one item per clock cycle and keeps doing so while the output
// register is drained in the same cycle. Interval registers are written through
// cfg_wen / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_long_press import kdlp_pkg::*; #(
	parameter int NUM_KEYS    = NUM_KEYS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wen,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [FIELD_KEYS-1:0] key_levels,
	input  wire logic [FIELD_KEYS-1:0] ack_mask,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [2*FIELD_KEYS-1:0]   key_states,
	output logic [FIELD_KEYS-1:0]     pending_mask,
	output logic [FIELD_KEYS-1:0]     press_events,
	output logic [FIELD_KEYS-1:0]     long_events
);

	logic [CFG_W-1:0]         debounce_q;
	logic [CFG_W-1:0]         long_press_q;
	logic                     in_fire;
	lane_res_t [NUM_KEYS-1:0] lane_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (cfg_wen) begin
			if (cfg_index == REG_DEBOUNCE) begin
				debounce_q <= cfg_data;
			end
			if (cfg_index == REG_LONG_PRESS) begin
				long_press_q <= cfg_data;
			end
		end
	end

	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;

	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
		logic down;
		logic ack;
		if (i < FIELD_KEYS) begin : g_pin
			assign down = ~key_levels[i];
			assign ack  = ack_mask[i];
		end else begin : g_nopin
			assign down = 1'b0;
			assign ack  = 1'b0;
		end
		kdlp_lane #(
			.COUNT_WIDTH (COUNT_WIDTH)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (in_fire),
			.down       (down),
			.ack        (ack),
			.debounce   (debounce_q),
			.long_press (long_press_q),
			.res        (lane_res[i])
		);
	end

	kdlp_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (in_fire),
		.out_ready    (out_ready),
		.lanes        (lane_res),
		.out_valid    (out_valid),
		.key_states   (key_states),
		.pending_mask (pending_mask),
		.press_events (press_events),
		.long_events  (long_events)
	);

`include "key_debounce_long_press_macros.svh"

	`KDLP_ASSERT_NXT(a_fire_gives_result, in_fire, out_valid)
	`KDLP_ASSERT_IMP(a_events_exclusive, out_valid, (press_events & long_events) == '0)
	`KDLP_ASSERT_IMP(a_event_sets_pending, out_valid,
		((press_events | long_events) & ~pending_mask) == '0)
	`KDLP_ASSERT_IMP(a_press_phase, out_valid && press_events[0],
		key_states[1:0] == PH_PRESSED)

endmodule

`default_nettype wire

[test/key_debounce_long_press_checker.sv]
// ----------------------------------------------------------------------------
// key_debounce_long_press_checker
// Watches the tick and result channels of the key debounce block, tracks the
// interval registers from the write port, predicts each result from its own
// per-key phase, counter and pending state, and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_debounce_long_press_checker import kdlp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [REG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [FIELD_KEYS-1:0]   key_levels,
	input  logic [FIELD_KEYS-1:0]   ack_mask,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic [2*FIELD_KEYS-1:0] key_states,
	input  logic [FIELD_KEYS-1:0]   pending_mask,
	input  logic [FIELD_KEYS-1:0]   press_events,
	input  logic [FIELD_KEYS-1:0]   long_events,
	output int                      fail_count,
	output int                      outstanding
);

	typedef struct packed {
		logic [2*FIELD_KEYS-1:0] states;
		logic [FIELD_KEYS-1:0]   pend;
		logic [FIELD_KEYS-1:0]   press;
		logic [FIELD_KEYS-1:0]   lng;
	} tick_result_t;

	logic [CFG_W-1:0]           debounce_ivl;
	logic [CFG_W-1:0]           long_ivl;
	phase_t                     lane_phase [FIELD_KEYS];
	logic [COUNT_WIDTH_DEF-1:0] lane_count [FIELD_KEYS];
	logic                       lane_pend  [FIELD_KEYS];
	tick_result_t               expected_ticks[$];

	function automatic tick_result_t predict_tick(logic [FIELD_KEYS-1:0] levels,
			logic [FIELD_KEYS-1:0] ack);
		tick_result_t               r;
		phase_t                     nxt;
		logic [COUNT_WIDTH_DEF-1:0] cnt;
		logic                       press_hit;
		logic                       lng_hit;
		r = '0;
		for (int k = 0; k < FIELD_KEYS; k++) begin
			cnt = lane_count[k];
			if (cnt != '1)
				cnt = cnt + 1'b1;
			nxt = lane_phase[k];
			press_hit = 1'b0;
			lng_hit = 1'b0;
			if (levels[k]) begin
				nxt = PH_IDLE;
			end else begin
				case (lane_phase[k])
					PH_IDLE: begin
						nxt = PH_QUAL;
						lane_pend[k] = 1'b0;
					end
					PH_QUAL: begin
						if (cnt >= debounce_ivl) begin
							nxt = PH_PRESSED;
							press_hit = 1'b1;
						end
					end
					PH_PRESSED: begin
						if (cnt >= long_ivl) begin
							nxt = PH_LONG;
							lng_hit = 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (nxt != lane_phase[k])
				cnt = '0;
			if (ack[k])
				lane_pend[k] = 1'b0;
			if (press_hit || lng_hit)
				lane_pend[k] = 1'b1;
			lane_phase[k] = nxt;
			lane_count[k] = cnt;
			r.states[2*k +: 2] = nxt;
			r.pend[k] = lane_pend[k];
			r.press[k] = press_hit;
			r.lng[k] = lng_hit;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_result_t exp_r;
		int           errs;
		errs = 0;
		if (!arst_n) begin
			debounce_ivl = DEBOUNCE_RST;
			long_ivl = LONG_PRESS_RST;
			for (int k = 0; k < FIELD_KEYS; k++) begin
				lane_phase[k] = PH_IDLE;
				lane_count[k] = '0;
				lane_pend[k] = 1'b0;
			end
			expected_ticks.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == REG_DEBOUNCE)
					debounce_ivl = cfg_data;
				else if (cfg_index == REG_LONG_PRESS)
					long_ivl = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (expected_ticks.size() == 0) begin
					$error("result item with no tick outstanding");
					errs = errs + 1;
				end else begin
					exp_r = expected_ticks.pop_front();
					if (key_states !== exp_r.states) begin
						$error("key_states: expected %h, got %h", exp_r.states, key_states);
						errs = errs + 1;
					end
					if (pending_mask !== exp_r.pend) begin
						$error("pending_mask: expected %h, got %h", exp_r.pend, pending_mask);
						errs = errs + 1;
					end
					if (press_events !== exp_r.press) begin
						$error("press_events: expected %h, got %h", exp_r.press, press_events);
						errs = errs + 1;
					end
					if (long_events !== exp_r.lng) begin
						$error("long_events: expected %h, got %h", exp_r.lng, long_events);
						errs = errs + 1;
					end
				end
			end
			if (in_valid && in_ready)
				expected_ticks.push_back(predict_tick(key_levels, ack_mask));
			fail_count <= fail_count + errs;
			outstanding <= expected_ticks.size();
		end
	end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Top level for the key debounce / long-press block: runs a directed pass
// over phase changes, acknowledges and interval extremes, then random key
// press sequences under several interval settings and idle patterns, with
// one long result stall, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import kdlp_pkg::*;;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_TICKS  = 185;
	localparam int NUM_PHASES   = 6;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_wen = 1'b0;
	logic [REG_IDX_W-1:0]    cfg_index = REG_DEBOUNCE;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [FIELD_KEYS-1:0]   key_levels = '1;
	logic [FIELD_KEYS-1:0]   ack_mask = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [2*FIELD_KEYS-1:0] key_states;
	logic [FIELD_KEYS-1:0]   pending_mask;
	logic [FIELD_KEYS-1:0]   press_events;
	logic [FIELD_KEYS-1:0]   long_events;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic burst_req = 1'b0;
	logic burst_done = 1'b0;
	int hold_left = 0;

	logic [CFG_W-1:0]      phase_debounce [NUM_PHASES] = '{16'd1, 16'd0, 16'd3, 16'd2, 16'd1, 16'd0};
	logic [CFG_W-1:0]      phase_long     [NUM_PHASES] = '{16'd2, 16'd4, 16'd0, 16'd6, 16'hffff, 16'd0};
	int                    run_left [FIELD_KEYS];
	logic [FIELD_KEYS-1:0] held_levels;

	key_debounce_long_press dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_levels   (key_levels),
		.ack_mask     (ack_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_states   (key_states),
		.pending_mask (pending_mask),
		.press_events (press_events),
		.long_events  (long_events)
	);

	key_debounce_long_press_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.key_levels   (key_levels),
		.ack_mask     (ack_mask),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.key_states   (key_states),
		.pending_mask (pending_mask),
		.press_events (press_events),
		.long_events  (long_events),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// hold off the result side for a long stretch once asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (burst_req && !burst_done) begin
			out_ready <= 1'b0;
			hold_left <= 300;
			burst_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic send_tick(input logic [FIELD_KEYS-1:0] lv, input logic [FIELD_KEYS-1:0] ak);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key_levels <= lv;
		ack_mask <= ak;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_intervals(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng);
		cfg_wen <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_data <= deb;
		@(posedge clk);
		cfg_index <= REG_LONG_PRESS;
		cfg_data <= lng;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int                    span;
		logic [FIELD_KEYS-1:0] lv;
		logic [FIELD_KEYS-1:0] ak;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset intervals: press and release well inside debounce
		send_tick(4'hf, 4'h0);
		send_tick(4'h0, 4'hf);
		send_tick(4'h0, 4'h0);
		send_tick(4'hf, 4'h0);
		wait_quiet();

		// zero intervals: confirm and go long on consecutive ticks
		set_intervals(16'd0, 16'd0);
		send_tick(4'b1110, 4'h0);
		send_tick(4'b1110, 4'h0);
		send_tick(4'b1110, 4'b0001);
		send_tick(4'b1110, 4'b0001);
		send_tick(4'hf, 4'h0);
		send_tick(4'h0, 4'h0);
		send_tick(4'h0, 4'h0);
		send_tick(4'b1010, 4'h0);
		send_tick(4'h0, 4'h0);
		send_tick(4'hf, 4'hf);
		wait_quiet();

		// largest intervals: keys stay qualifying
		set_intervals(16'hffff, 16'hffff);
		send_tick(4'h0, 4'h0);
		send_tick(4'h0, 4'h0);
		send_tick(4'b0101, 4'b1010);
		send_tick(4'hf, 4'h5);
		wait_quiet();

		for (int p = 0; p < NUM_PHASES; p++) begin
			set_intervals(phase_debounce[p], phase_long[p]);
			if (p < 2) begin
				tx_idle_pct = 32;
				rx_idle_pct <= 83;
			end else if (p < 4) begin
				tx_idle_pct = 83;
				rx_idle_pct <= 32;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			if (p == 4)
				burst_req <= 1'b1;
			held_levels = '1;
			for (int k = 0; k < FIELD_KEYS; k++)
				run_left[k] = $urandom_range(1, 4);
			span = phase_debounce[p] + phase_long[p] + 4;
			if (span > 24)
				span = 24;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				for (int k = 0; k < FIELD_KEYS; k++) begin
					if (run_left[k] == 0) begin
						held_levels[k] = ~held_levels[k];
						run_left[k] = held_levels[k] ? $urandom_range(1, 6) :
							$urandom_range(1, span);
					end
					run_left[k] = run_left[k] - 1;
				end
				lv = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : held_levels;
				if ($urandom_range(0, 7) == 0) begin
					ak = 4'($urandom_range(0, 15));
				end else begin
					for (int k = 0; k < FIELD_KEYS; k++)
						ak[k] = ($urandom_range(0, 3) == 0);
				end
				send_tick(lv, ak);
			end
			wait_quiet();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/kdlp_pkg.sv
hw/rtl/kdlp_lane.sv
hw/rtl/kdlp_merge.sv
hw/rtl/key_debounce_long_press.sv
test/key_debounce_long_press_checker.sv
test/tb.sv
